// ----- rtl/core/krt_pkg.sv -----
// Package for the keyed ring table: transaction payload types, operation and
// status codes, and the command and status structs between controller and datapath.
// No dependencies.
package krt_pkg;

    localparam logic [1:0] OP_BOOK   = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;
    localparam logic [1:0] OP_EDIT   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic [15:0] FIRST_ID = 16'd101;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] key_id;
        logic [7:0]  payload;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] result_id;
        logic [7:0]  result_payload;
    } rsp_t;

    typedef struct packed {
        logic       load;
        logic       idx_clr;
        logic       idx_inc;
        logic       rd_adv;
        logic       wr_book;
        logic       wr_edit;
        logic       wr_shift;
        logic       wr_clear;
        logic       stage_found;
        logic       stage_book;
        logic       stage_fail;
        logic [1:0] fail_code;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       empty;
        logic       match;
        logic       last;
    } sts_t;

endpackage

// ----- rtl/core/keyed_ring_table.sv -----
// Top level of the keyed ring table: joins the controller and the datapath.
// Depends on krt_pkg, krt_ctrl and krt_dpath.
//
// Usage: one request transaction (op, key_id, payload) on req gives exactly one
// response transaction (status, result_id, result_payload) on rsp, in order.
// Book appends a record with the next id; cancel, lookup and edit act on the
// first live record whose id matches key_id.
// Steps: book and every empty-table case are decided in the dispatch state and
// pass to the finish state, which loads the response register. A search spends a
// read state and a compare state on each record examined, and a cancel then moves
// each later record down with a check state and a write state, then clears the
// vacated slot, as the record memories have a single read and write port.
// One request is in work at a time; req_ready is high only while the
// controller waits for a request, from the cycle after the response loads.
// Stall: the response register holds a finished transaction while rsp_ready is
// low; a further request is accepted and worked, then waits for that register.
// Reset: the table is empty and the id counter restarts at 101; no clearing
// pass is needed, so requests are taken from the first cycle after reset.
module keyed_ring_table #(
    parameter int SLOTS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  krt_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output krt_pkg::rsp_t rsp
);
    import krt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    krt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    krt_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule

// ----- rtl/core/krt_dpath.sv -----
// Datapath of the keyed ring table: record memories, entry count, id counter,
// scan index, result staging and output register. Depends on krt_pkg.
module krt_dpath #(
    parameter int SLOTS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  krt_pkg::req_t req,
    input  krt_pkg::cmd_t cmd,
    output krt_pkg::sts_t sts,
    output krt_pkg::rsp_t rsp
);
    import krt_pkg::*;

    localparam int IW = $clog2(SLOTS);

    logic [15:0]   id_mem  [SLOTS];
    logic [7:0]    pay_mem [SLOTS];

    req_t          req_reg;
    logic [IW-1:0] count_reg, count_next;
    logic [15:0]   next_id_reg, next_id_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [15:0]   rd_id_reg;
    logic [7:0]    rd_pay_reg;
    rsp_t          stage_reg, stage_next;
    rsp_t          rsp_reg;

    logic [IW-1:0] idx_plus;
    logic [IW-1:0] count_minus;
    logic [IW-1:0] rd_addr;
    logic          wr_id_en;
    logic          wr_pay_en;
    logic [IW-1:0] wr_addr;
    logic [15:0]   wr_id;
    logic [7:0]    wr_pay;

    assign idx_plus    = idx_reg + IW'(1);
    assign count_minus = count_reg - IW'(1);
    assign rd_addr     = cmd.rd_adv ? idx_plus : idx_reg;

    always_comb
    begin
        wr_id_en  = 1'b0;
        wr_pay_en = 1'b0;
        wr_addr   = idx_reg;
        wr_id     = rd_id_reg;
        wr_pay    = rd_pay_reg;
        if (cmd.wr_book)
        begin
            wr_id_en  = 1'b1;
            wr_pay_en = 1'b1;
            wr_addr   = count_reg;
            wr_id     = next_id_reg;
            wr_pay    = req_reg.payload;
        end
        else if (cmd.wr_shift)
        begin
            wr_id_en  = 1'b1;
            wr_pay_en = 1'b1;
        end
        else if (cmd.wr_clear)
        begin
            wr_id_en  = 1'b1;
            wr_pay_en = 1'b1;
            wr_addr   = count_minus;
            wr_id     = '0;
            wr_pay    = '0;
        end
        else if (cmd.wr_edit)
        begin
            wr_pay_en = 1'b1;
            wr_pay    = req_reg.payload;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_id_en)
        begin
            id_mem[wr_addr] <= wr_id;
        end
        if (wr_pay_en)
        begin
            pay_mem[wr_addr] <= wr_pay;
        end
        rd_id_reg  <= id_mem[rd_addr];
        rd_pay_reg <= pay_mem[rd_addr];
    end

    always_comb
    begin
        count_next   = count_reg;
        next_id_next = next_id_reg;
        idx_next     = idx_reg;
        stage_next   = stage_reg;
        if (cmd.wr_book)
        begin
            count_next   = count_reg + IW'(1);
            next_id_next = next_id_reg + 16'd1;
        end
        else if (cmd.wr_clear)
        begin
            count_next = count_minus;
        end
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_plus;
        end
        if (cmd.stage_book)
        begin
            stage_next.status         = ST_OK;
            stage_next.result_id      = next_id_reg;
            stage_next.result_payload = req_reg.payload;
        end
        else if (cmd.stage_found)
        begin
            stage_next.status         = ST_OK;
            stage_next.result_id      = rd_id_reg;
            stage_next.result_payload = (req_reg.op == OP_EDIT) ? req_reg.payload : rd_pay_reg;
        end
        else if (cmd.stage_fail)
        begin
            stage_next.status         = cmd.fail_code;
            stage_next.result_id      = '0;
            stage_next.result_payload = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            next_id_reg <= FIRST_ID;
        end
        else
        begin
            count_reg   <= count_next;
            next_id_reg <= next_id_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        stage_reg <= stage_next;
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.out_load)
        begin
            rsp_reg <= stage_reg;
        end
    end

    assign sts.op    = req_reg.op;
    assign sts.full  = (count_reg == IW'(SLOTS - 1));
    assign sts.empty = (count_reg == '0);
    assign sts.match = (rd_id_reg == req_reg.key_id);
    assign sts.last  = (idx_reg == count_minus);
    assign rsp       = rsp_reg;

endmodule

// ----- rtl/core/krt_ctrl.sv -----
// Controller of the keyed ring table: sequences search, shift and update steps
// and runs the request and response handshakes. Depends on krt_pkg.
module krt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    input  krt_pkg::sts_t sts,
    output krt_pkg::cmd_t cmd
);
    import krt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_READ,
        S_COMPARE,
        S_SHIFT_CHK,
        S_SHIFT_WR,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg & ~rsp_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load    = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (sts.op == OP_BOOK)
                begin
                    if (sts.full)
                    begin
                        cmd.stage_fail = 1'b1;
                        cmd.fail_code  = ST_FULL;
                    end
                    else
                    begin
                        cmd.wr_book    = 1'b1;
                        cmd.stage_book = 1'b1;
                    end
                    state_next = S_FINISH;
                end
                else if (sts.empty)
                begin
                    cmd.stage_fail = 1'b1;
                    cmd.fail_code  = ST_EMPTY;
                    state_next     = S_FINISH;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_COMPARE;
            end
            S_COMPARE:
            begin
                if (sts.match)
                begin
                    cmd.stage_found = 1'b1;
                    if (sts.op == OP_CANCEL)
                    begin
                        state_next = S_SHIFT_CHK;
                    end
                    else
                    begin
                        cmd.wr_edit = (sts.op == OP_EDIT);
                        state_next  = S_FINISH;
                    end
                end
                else if (sts.last)
                begin
                    cmd.stage_fail = 1'b1;
                    cmd.fail_code  = ST_NOTFOUND;
                    state_next     = S_FINISH;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_SHIFT_CHK:
            begin
                if (sts.last)
                begin
                    cmd.wr_clear = 1'b1;
                    state_next   = S_FINISH;
                end
                else
                begin
                    cmd.rd_adv = 1'b1;
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = S_SHIFT_CHK;
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.out_load   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

// ----- rtl/core/krt_checker.sv -----
// Port checker for the keyed ring table, bound to the top level.
// Depends on krt_pkg and keyed_ring_table.
module krt_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input krt_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input krt_pkg::rsp_t rsp
);
    import krt_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp))
        else $error("response changed while stalled");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_OK) |->
            (rsp.result_id == 16'd0) && (rsp.result_payload == 8'd0))
        else $error("failed transaction carries a non-zero record");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in work");

endmodule

bind keyed_ring_table krt_checker u_krt_checker (.*);
